@@ sv/ugcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugcd_pkg: shared definitions for the undirected graph cycle detector
// Widths, operation and status codes, register map and search response type.
// ----------------------------------------------------------------------------
package ugcd_pkg;

  // Field widths
  localparam int unsigned NODE_W   = 7;
  localparam int unsigned EDGE_W   = 2 * NODE_W;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned REG_W    = ADDR_W - 2;

  // Largest node number a node field can carry
  localparam int unsigned NODE_MAX = (1 << NODE_W) - 1;

  // Parameter defaults
  localparam int unsigned DEF_MAX_NODES = 64;
  localparam int unsigned DEF_MAX_EDGES = 256;

  // Register map and reset values
  localparam logic [REG_W-1:0]  REG_NODE_COUNT = 1'b0;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  // Operation codes
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_DETECT   = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

  // Search engine response
  typedef struct packed {
    logic done;
    logic cycle;
  } srch_rsp_t;

  // Highest node number that is searched for a given node capacity
  function automatic int unsigned live_cap(input int unsigned max_nodes);
    return (max_nodes < NODE_MAX) ? max_nodes : NODE_MAX;
  endfunction

endpackage

@@ sv/ugcd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugcd_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ugcd_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ugcd_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugcd_search: breadth-first search engine
// Clears the visited marks in one pass, walks every unvisited start node,
// queues (node, parent) pairs and scans the edge store once per dequeued node
// through one shared compare unit. Visited marks live in a small RAM.
// ----------------------------------------------------------------------------
module ugcd_search #(
  parameter int unsigned MAX_NODES = ugcd_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = ugcd_pkg::DEF_MAX_EDGES,
  localparam int unsigned ET_W = $clog2(MAX_EDGES + 1),
  localparam int unsigned EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [ugcd_pkg::NODE_W-1:0]  node_live_i,
  input  logic [ET_W-1:0]              edge_total_i,
  output logic [EA_W-1:0]              edge_raddr_o,
  input  logic [ugcd_pkg::EDGE_W-1:0]  edge_rdata_i,
  output logic                         busy_o,
  output ugcd_pkg::srch_rsp_t          rsp_o
);

  import ugcd_pkg::*;

  localparam int unsigned VIS_N  = live_cap(MAX_NODES) + 1;
  localparam int unsigned VIS_AW = $clog2(VIS_N);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_POP   = 4'd4;
  localparam logic [3:0] ST_NODE  = 4'd5;
  localparam logic [3:0] ST_EREAD = 4'd6;
  localparam logic [3:0] ST_EPROC = 4'd7;
  localparam logic [3:0] ST_EVIS  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [NODE_W:0]   start_q, start_d;
  logic [VIS_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0] node_q, node_d, par_q, par_d, nb_q, nb_d;
  logic [ET_W-1:0]   eidx_q, eidx_d;

  logic              q_we;
  logic [VIS_AW-1:0] q_waddr;
  logic [EDGE_W-1:0] q_wdata;
  logic [EDGE_W-1:0] q_rdata;

  logic              v_we;
  logic [VIS_AW-1:0] v_waddr;
  logic              v_wdata;
  logic [VIS_AW-1:0] v_raddr;
  logic              v_rdata;

  logic [NODE_W-1:0] edge_a, edge_b, nb;
  logic              in_range, hit_a, hit;

  // Queue of (node, parent) pairs
  ugcd_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (VIS_N),
    .AW    (VIS_AW)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  // Visited marks, one bit per node
  ugcd_ram #(
    .WIDTH (1),
    .DEPTH (VIS_N),
    .AW    (VIS_AW)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // Shared compare unit: decide which neighbor an edge gives the current node
  assign edge_a   = edge_rdata_i[EDGE_W-1:NODE_W];
  assign edge_b   = edge_rdata_i[NODE_W-1:0];
  assign in_range = (edge_a != '0) && (edge_b != '0) &&
                    (edge_a <= node_live_i) && (edge_b <= node_live_i);
  assign hit_a    = (edge_a == node_q);
  assign hit      = in_range && (hit_a || (edge_b == node_q));
  assign nb       = hit_a ? edge_b : edge_a;

  assign edge_raddr_o = eidx_q[EA_W-1:0];
  assign busy_o       = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    start_d = start_q;
    head_d  = head_q;
    tail_d  = tail_q;
    node_d  = node_q;
    par_d   = par_q;
    nb_d    = nb_q;
    eidx_d  = eidx_q;
    q_we    = 1'b0;
    q_waddr = tail_q;
    q_wdata = {nb_q, node_q};
    v_we    = 1'b0;
    v_waddr = nb_q[VIS_AW-1:0];
    v_wdata = 1'b1;
    v_raddr = start_q[VIS_AW-1:0];
    rsp_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          start_d = (NODE_W + 1)'(1);
          state_d = ST_CLEAR;
        end
      end
      // drop the marks of nodes 1..node_live, one per cycle
      ST_CLEAR: begin
        if (start_q > {1'b0, node_live_i}) begin
          start_d = (NODE_W + 1)'(1);
          state_d = ST_START;
        end else begin
          v_we    = 1'b1;
          v_waddr = start_q[VIS_AW-1:0];
          v_wdata = 1'b0;
          start_d = start_q + 1'b1;
        end
      end
      // read the mark of the next start node
      ST_START: begin
        if (start_q > {1'b0, node_live_i}) begin
          rsp_o.done = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (v_rdata) begin
          start_d = start_q + 1'b1;
          state_d = ST_START;
        end else begin
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = {start_q[NODE_W-1:0], {NODE_W{1'b0}}};
          v_we    = 1'b1;
          v_waddr = start_q[VIS_AW-1:0];
          head_d  = '0;
          tail_d  = VIS_AW'(1);
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          start_d = start_q + 1'b1;
          state_d = ST_START;
        end else begin
          head_d  = head_q + 1'b1;
          state_d = ST_NODE;
        end
      end
      ST_NODE: begin
        node_d  = q_rdata[EDGE_W-1:NODE_W];
        par_d   = q_rdata[NODE_W-1:0];
        eidx_d  = '0;
        state_d = ST_EREAD;
      end
      ST_EREAD: begin
        if (eidx_q == edge_total_i) begin
          state_d = ST_POP;
        end else begin
          eidx_d  = eidx_q + 1'b1;
          state_d = ST_EPROC;
        end
      end
      // hold the neighbor and read its mark
      ST_EPROC: begin
        v_raddr = nb[VIS_AW-1:0];
        nb_d    = nb;
        state_d = hit ? ST_EVIS : ST_EREAD;
      end
      ST_EVIS: begin
        state_d = ST_EREAD;
        if (!v_rdata) begin
          q_we   = 1'b1;
          tail_d = tail_q + 1'b1;
          v_we   = 1'b1;
        end else if (nb_q != par_q) begin
          rsp_o.done  = 1'b1;
          rsp_o.cycle = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search counters and current node
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    node_q  <= node_d;
    par_q   <= par_d;
    nb_q    <= nb_d;
    eidx_q  <= eidx_d;
  end

endmodule

@@ sv/undirected_graph_cycle_detect.sv @@
`timescale 1ns / 1ps
// Edge transaction: busy stays low, so one edge may follow every cycle.
// Detect transaction: busy while the search runs: a clearing pass over the visited marks
// of the N nodes in use, then a check of each start node tried, S searches started,
// and a scan of all E stored edges for each of the P nodes dequeued.
// valid_o pulses in the cycle in which busy falls; the receiver cannot stall it.
// Reset: async active low; clears edges and errors; node_count = 64.
// ----------------------------------------------------------------------------
// undirected_graph_cycle_detect: cycle detector for an undirected graph
// Loads edges over the command port and runs a breadth-first search on detect.
// ----------------------------------------------------------------------------
module undirected_graph_cycle_detect #(
  parameter int unsigned MAX_NODES = ugcd_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = ugcd_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ugcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ugcd_pkg::DATA_W-1:0]   pwdata,
  output logic [ugcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Command port
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [ugcd_pkg::NODE_W-1:0]   end_a_i,
  input  logic [ugcd_pkg::NODE_W-1:0]   end_b_i,
  // Result port
  output logic                          valid_o,
  output logic                          has_cycle_o,
  output logic [ugcd_pkg::STATUS_W-1:0] status_o
);

  import ugcd_pkg::*;

  localparam int unsigned LIVE_CAP = live_cap(MAX_NODES);
  localparam int unsigned ET_W     = $clog2(MAX_EDGES + 1);
  localparam int unsigned EA_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [NODE_W-1:0]   node_count_q;
  logic [NODE_W-1:0]   node_live;
  logic [ET_W-1:0]     edge_total_q;
  logic [STATUS_W-1:0] load_error_q;
  logic                valid_q;
  logic                has_cycle_q;
  logic [STATUS_W-1:0] status_q;

  logic                cfg_we;
  logic [REG_W-1:0]    reg_idx;
  logic                accept, edge_acc, go;
  logic                end_bad, store_full, edge_we;
  logic [EA_W-1:0]     edge_raddr;
  logic [EDGE_W-1:0]   edge_rdata;
  srch_rsp_t           rsp;

  // Configuration register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == REG_NODE_COUNT);

  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT: prdata = {{(DATA_W - NODE_W){1'b0}}, node_count_q};
      default:        prdata = '0;
    endcase
  end

  // Clamp the node count to the capacity of the visited set
  assign node_live = (node_count_q > NODE_W'(LIVE_CAP)) ? NODE_W'(LIVE_CAP) : node_count_q;

  // Decode the accepted transaction
  assign accept     = start && !busy;
  assign edge_acc   = accept && (operation_i == OP_ADD_EDGE);
  assign go         = accept && (operation_i == OP_DETECT);
  assign end_bad    = (end_a_i == '0) || (end_b_i == '0) ||
                      (end_a_i > node_live) || (end_b_i > node_live);
  assign store_full = (edge_total_q >= ET_W'(MAX_EDGES));
  assign edge_we    = edge_acc && !end_bad && !store_full;

  // Edge store
  ugcd_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES),
    .AW    (EA_W)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_total_q[EA_W-1:0]),
    .wdata_i ({end_a_i, end_b_i}),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // Search engine
  ugcd_search #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (go),
    .node_live_i  (node_live),
    .edge_total_i (edge_total_q),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata),
    .busy_o       (busy),
    .rsp_o        (rsp)
  );

  // Control state: node count, edge count, sticky error, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      edge_total_q <= '0;
      load_error_q <= STAT_OK;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= rsp.done;
      if (cfg_we) begin
        node_count_q <= pwdata[NODE_W-1:0];
      end
      if (rsp.done) begin
        edge_total_q <= '0;
        load_error_q <= STAT_OK;
      end else if (edge_acc) begin
        if (end_bad) begin
          if (load_error_q == STAT_OK) begin
            load_error_q <= STAT_RANGE;
          end
        end else if (store_full) begin
          if (load_error_q == STAT_OK) begin
            load_error_q <= STAT_OVERFLOW;
          end
        end else begin
          edge_total_q <= edge_total_q + 1'b1;
        end
      end
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (rsp.done) begin
      has_cycle_q <= rsp.cycle;
      status_q    <= load_error_q;
    end
  end

  assign valid_o     = valid_q;
  assign has_cycle_o = has_cycle_q;
  assign status_o    = status_q;

  // A result only follows a running search
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a preceding search");

  // The edge count never passes the store depth
  a_edge_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= ET_W'(MAX_EDGES))
    else $error("edge count beyond store depth");

  // The edge count holds while a search runs
  a_edges_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> $stable(edge_total_q))
    else $error("edge count changed during search");

  // A result always carries a defined status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == STAT_OK || status_o == STAT_OVERFLOW ||
                 status_o == STAT_RANGE))
    else $error("undefined status code");

endmodule
